/* design/dlp_pkg.sv */
// ----------------------------------------------------------------------------
// dlp_pkg: shared constants and the power-of-ten function of the decimal line parser
// Field widths, character codes, register indexes and the power-of-ten table.
// ----------------------------------------------------------------------------
package dlp_pkg;

	// Fixed widths of the channel fields.
	localparam int TEXT_W    = 8;
	localparam int SIGNAL_W  = 48;
	localparam int INDEX_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 48;

	// Width of one entry of the power-of-ten table (10^8 needs 27 bits).
	localparam int POW_W = 27;

	// Character codes that steer the parser.
	localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [TEXT_W-1:0] CH_MINUS   = 8'd45;
	localparam logic [TEXT_W-1:0] CH_POINT   = 8'd46;
	localparam logic [TEXT_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [TEXT_W-1:0] CH_NINE    = 8'd57;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_TRIGGER  = 2'd1;

	// Powers of ten from 10^0 to 10^8; larger exponents give the top entry.
	function automatic logic [POW_W-1:0] pow_ten(input logic [3:0] e);
		logic [POW_W-1:0] r;
		case (e)
			4'd0:    r = 27'd1;
			4'd1:    r = 27'd10;
			4'd2:    r = 27'd100;
			4'd3:    r = 27'd1000;
			4'd4:    r = 27'd10000;
			4'd5:    r = 27'd100000;
			4'd6:    r = 27'd1000000;
			4'd7:    r = 27'd10000000;
			default: r = 27'd100000000;
		endcase
		return r;
	endfunction

endpackage

/* design/dlp_byte_if.sv */
// ----------------------------------------------------------------------------
// dlp_byte_if: text byte channel
// Valid/ready channel carrying one byte of the text stream per item.
// ----------------------------------------------------------------------------
interface dlp_byte_if import dlp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TEXT_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

/* design/dlp_signal_if.sv */
// ----------------------------------------------------------------------------
// dlp_signal_if: signal result channel
// Valid/ready channel carrying one emitted line value and its index.
// ----------------------------------------------------------------------------
interface dlp_signal_if import dlp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SIGNAL_W-1:0] signal_value;
	logic [INDEX_W-1:0]         signal_index;

	modport source (output valid, output signal_value, output signal_index, input ready);
	modport sink   (input valid, input signal_value, input signal_index, output ready);
endinterface

/* design/dlp_cfg_if.sv */
// ----------------------------------------------------------------------------
// dlp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ----------------------------------------------------------------------------
interface dlp_cfg_if import dlp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/decimal_line_parse_threshold_filter_unit.sv */
// ----------------------------------------------------------------------------
// decimal_line_parse_threshold_filter_unit: decimal line parser and filter
// Parses a decimal number at the start of each text line and emits the lines
// whose value passes the threshold and change filters.
// ----------------------------------------------------------------------------
// Usage:
//   text_in    - one text byte per item; byte 10 ends a line.
//   signal_out - one item per emitted line: the value in decimal fixed point
//                (scaled by ten to FRAC_DIGITS) and the count of signals
//                emitted before it, saturating at its maximum.
//   cfg        - register writes: index 0 value threshold, index 1 change
//                trigger; always ready; the user must write them only while
//                the block is idle; the block itself does not enforce this.
// Throughput is one byte per cycle while the line queue has room. A result
// moves from the newline that ends its line through the line queue and the
// compare stage to the output register. When signal_out stalls, parsed lines
// collect in a four-entry queue and text_in stays ready until it fills.
// Reset clears the parser, the previous line value, the signal counter and
// both configuration registers to zero.
// ----------------------------------------------------------------------------
module decimal_line_parse_threshold_filter_unit import dlp_pkg::*; #(
	parameter int FRAC_DIGITS = 4,
	parameter int VALUE_BITS  = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	dlp_byte_if.sink     text_in,
	dlp_signal_if.source signal_out,
	dlp_cfg_if.sink      cfg
);

	localparam int QUEUE_DEPTH = 4;

	logic                         push_valid;
	logic signed [VALUE_BITS-1:0] push_data;
	logic                         full;
	logic                         pop_valid;
	logic                         pop_ready;
	logic signed [VALUE_BITS-1:0] pop_data;

	// Parser front end.
	dlp_front #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (full)
	);

	// Queue of finished line values.
	dlp_queue #(
		.WIDTH (VALUE_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Filter back end.
	dlp_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.cfg        (cfg),
		.signal_out (signal_out)
	);

endmodule

/* design/dlp_front.sv */
// ----------------------------------------------------------------------------
// dlp_front: line parser
// Accepts one text byte per cycle while the queue has room, accumulates the
// number at the start of the line and pushes the signed value on a newline.
// ----------------------------------------------------------------------------
module dlp_front import dlp_pkg::*; #(
	parameter int FRAC_DIGITS = 4,
	parameter int VALUE_BITS  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dlp_byte_if.sink                     text_in,
	output logic                         push_valid,
	output logic signed [VALUE_BITS-1:0] push_data,
	input  logic                         full
);

	localparam int MAG_W = VALUE_BITS - 1;
	localparam int SUM_W = (VALUE_BITS + 4 > 33) ? VALUE_BITS + 4 : 33;
	localparam logic [POW_W-1:0] SCALE = pow_ten(4'(FRAC_DIGITS));
	localparam logic [SUM_W-1:0] MAG_MAX = SUM_W'({MAG_W{1'b1}});

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_INT   = 4'b0010,
		PH_FRAC  = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	phase_t             phase_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [3:0]         cnt_q;

	logic               accept;
	logic               is_digit;
	logic               is_newline;
	logic [3:0]         digit;
	logic [3:0]         cnt_inc;
	logic [SUM_W-1:0]   mag_ext;
	logic [SUM_W-1:0]   int_sum;
	logic [SUM_W-1:0]   frac_sum;
	logic [MAG_W-1:0]   int_next;
	logic [MAG_W-1:0]   frac_next;
	logic signed [VALUE_BITS-1:0] mag_s;

	// Byte classification; the low nibble of a digit code is its value.
	assign text_in.ready = !full;
	assign accept        = text_in.valid && text_in.ready;
	assign is_newline    = (text_in.text_byte == CH_NEWLINE);
	assign is_digit      = (text_in.text_byte >= CH_ZERO) && (text_in.text_byte <= CH_NINE);
	assign digit         = text_in.text_byte[3:0];
	assign cnt_inc       = cnt_q + 4'd1;

	// Integer digit: magnitude times ten plus the scaled digit, saturating.
	// Fraction digit: add the digit at its decimal weight, saturating.
	always_comb begin
		mag_ext   = SUM_W'(mag_q);
		int_sum   = (mag_ext << 3) + (mag_ext << 1) + SUM_W'(digit) * SUM_W'(SCALE);
		frac_sum  = mag_ext
			+ SUM_W'(digit) * SUM_W'(pow_ten(4'(FRAC_DIGITS) - cnt_inc));
		int_next  = (int_sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : int_sum[MAG_W-1:0];
		frac_next = (frac_sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : frac_sum[MAG_W-1:0];
	end

	// Signed line value handed to the queue on a newline.
	assign mag_s      = {1'b0, mag_q};
	assign push_data  = neg_q ? -mag_s : mag_s;
	assign push_valid = accept && is_newline;

	// Parser state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (is_newline) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				cnt_q   <= '0;
			end else begin
				case (phase_q)
					PH_START: begin
						if (text_in.text_byte == CH_MINUS) begin
							neg_q   <= 1'b1;
							phase_q <= PH_INT;
						end else if (is_digit) begin
							mag_q   <= int_next;
							phase_q <= PH_INT;
						end else if (text_in.text_byte == CH_POINT) begin
							phase_q <= PH_FRAC;
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					PH_INT: begin
						if (is_digit) begin
							mag_q <= int_next;
						end else if (text_in.text_byte == CH_POINT) begin
							phase_q <= PH_FRAC;
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					PH_FRAC: begin
						if (is_digit) begin
							if (cnt_q < 4'(FRAC_DIGITS)) begin
								cnt_q <= cnt_inc;
								mag_q <= frac_next;
							end
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* design/dlp_queue.sv */
// ----------------------------------------------------------------------------
// dlp_queue: line value queue
// Short first-in first-out queue of parsed line values between the parser
// and the filter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module dlp_queue import dlp_pkg::*; #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	input  logic signed [WIDTH-1:0] push_data,
	output logic                    full,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output logic signed [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	// Storage for queued line values.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// A line value offered while the queue is full would be lost.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && full))
		else $error("line value pushed into a full queue");

endmodule

/* design/dlp_back.sv */
// ----------------------------------------------------------------------------
// dlp_back: threshold and change filter
// Holds the configuration registers, compares each line value with the
// threshold and with the previous line's value, and drives the signal
// output register with a saturating signal index.
// ----------------------------------------------------------------------------
module dlp_back import dlp_pkg::*; #(
	parameter int VALUE_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  logic signed [VALUE_BITS-1:0] pop_data,
	dlp_cfg_if.sink                      cfg,
	dlp_signal_if.source                 signal_out
);

	localparam int DIFF_W = VALUE_BITS + 1;
	localparam int CMP_W  = ((DIFF_W > CFG_W) ? DIFF_W : CFG_W) + 1;

	logic signed [CFG_W-1:0]      thr_q;
	logic signed [CFG_W-1:0]      trig_q;
	logic signed [VALUE_BITS-1:0] prev_q;
	logic [INDEX_W-1:0]           cnt_q;

	logic                         s1_valid_q;
	logic signed [VALUE_BITS-1:0] cur_s1;
	logic signed [DIFF_W-1:0]     diff_s1;
	logic                         gt_s1;

	logic                         out_valid_q;
	logic signed [SIGNAL_W-1:0]   value_q;
	logic [INDEX_W-1:0]           index_q;

	logic                         do_pop;
	logic                         s1_adv;
	logic signed [DIFF_W-1:0]     abs_diff;
	logic                         pass;
	logic                         load_out;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			trig_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_VALUE_THRESHOLD: thr_q  <= cfg.data;
				REG_CHANGE_TRIGGER:  trig_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Handshake between the queue, the compare stage and the output register.
	assign s1_adv    = !out_valid_q || signal_out.ready;
	assign pop_ready = !s1_valid_q || s1_adv;
	assign do_pop    = pop_valid && pop_ready;

	// Second compare: absolute change against the trigger.
	assign abs_diff = diff_s1[DIFF_W-1] ? -diff_s1 : diff_s1;
	assign pass     = gt_s1 && (CMP_W'(abs_diff) > CMP_W'(trig_q));
	assign load_out = s1_valid_q && s1_adv && pass;

	// Compare stage: difference from the previous value and threshold test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			prev_q     <= '0;
		end else if (do_pop) begin
			s1_valid_q <= 1'b1;
			prev_q     <= pop_data;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			cur_s1  <= pop_data;
			diff_s1 <= DIFF_W'(pop_data) - DIFF_W'(prev_q);
			gt_s1   <= (CMP_W'(pop_data) > CMP_W'(thr_q));
		end
	end

	// Output register and saturating signal counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= s1_valid_q && pass;
			end
			if (load_out && (cnt_q != '1)) begin
				cnt_q <= cnt_q + INDEX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= SIGNAL_W'(cur_s1);
			index_q <= cnt_q;
		end
	end

	assign signal_out.valid        = out_valid_q;
	assign signal_out.signal_value = value_q;
	assign signal_out.signal_index = index_q;

	// The counter moves only when a signal is loaded.
	a_cnt_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!load_out |=> $stable(cnt_q))
		else $error("signal counter changed without a signal");

	// A loaded index is one below the counter, unless the counter is saturated.
	a_index_matches_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (index_q == cnt_q - INDEX_W'(1)) || (cnt_q == '1))
		else $error("signal index out of step with the counter");

	// A stalled output holds the compare stage in place.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !signal_out.ready)
			|=> (s1_valid_q && $stable(cur_s1)))
		else $error("compare stage moved while the output was stalled");

endmodule
